[rtl/core/ffla_pkg.sv]
// Shared types and constants for the FIFO free-list allocator.
// Holds the item structs, the opcodes and the controller/datapath links.
// No dependencies.
package ffla_pkg;

    // Width of the entry index fields on the item ports.
    localparam int unsigned IDX_FIELD_W = 6;

    // Request opcodes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // One request item.
    typedef struct packed {
        logic                   opcode;
        logic [IDX_FIELD_W-1:0] release_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [IDX_FIELD_W-1:0] granted_index;
        logic                   success;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_en;  // write one entry of the clearing pass
        logic accept;   // take the request item and start its memory reads
        logic exec;     // apply the request and load the result register
        logic link_wr;  // hook the released entry behind the old tail
    } t_ffla_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;  // clearing pass is at the last entry
        logic out_free;   // result register can take a new item this cycle
        logic need_link;  // valid release onto a non-empty list must be linked behind the tail
    } t_ffla_status;

endpackage

[rtl/core/ffla_ctrl.sv]
// Controller state machine of the FIFO free-list allocator.
// Sequences the clearing pass and the steps of each request.
// Depends on ffla_pkg.
module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_ffla_status i_status,
    output t_ffla_cmd    o_cmd
);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_LINK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_en = 1'b1;
                if (i_status.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result can only be produced when the output register is free.
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.need_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK: begin
                o_cmd.link_wr = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/ffla_dp.sv]
// Datapath of the FIFO free-list allocator.
// Holds the link and in-use memories, head/tail pointers and the result register.
// Depends on ffla_pkg.
module ffla_dp
    import ffla_pkg::*;
#(
    parameter int NUM_ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ffla_cmd    i_cmd,
    input  t_in_item     i_in_item,
    output t_ffla_status o_status,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_out_item    o_out_item
);

    localparam int IW    = $clog2(NUM_ENTRIES);
    localparam int EXT_W = ((IW > int'(IDX_FIELD_W)) ? IW : int'(IDX_FIELD_W)) + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    // Free-list links and in-use flags, one entry per pool slot.
    logic [IW-1:0] r_link   [NUM_ENTRIES];
    logic          r_in_use [NUM_ENTRIES];

    logic [IW-1:0] r_init_cnt;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic          r_empty;

    logic          r_op;
    logic [IW-1:0] r_rel_idx;
    logic          r_rel_in_range;
    logic [IW-1:0] r_link_rd;
    logic          r_use_rd;
    logic [IW-1:0] r_link_addr;

    logic          r_out_valid;
    t_out_item     r_out_item;

    logic [IW-1:0] rd_rel_idx;
    logic          rd_in_range;
    logic          alloc_ok;
    logic          rel_ok;
    logic          use_wr_en;
    logic [IW-1:0] use_wr_addr;
    logic          use_wr_data;
    logic [IW-1:0] init_link;

    // Request index as seen at the input port.
    assign rd_rel_idx  = IW'(i_in_item.release_index);
    assign rd_in_range = (EXT_W'(i_in_item.release_index) < EXT_W'(NUM_ENTRIES));

    // Outcome of the request held for execution.
    assign alloc_ok = (r_op == OP_ALLOC) && !r_empty;
    assign rel_ok   = (r_op == OP_RELEASE) && r_rel_in_range && r_use_rd;

    // Clearing pass chains every entry to the next; the last one links to zero.
    assign init_link = (r_init_cnt == LAST_IDX) ? '0 : r_init_cnt + IW'(1);

    // In-use memory write port: clearing pass, grant, or release.
    always_comb begin
        use_wr_en   = 1'b0;
        use_wr_addr = r_init_cnt;
        use_wr_data = 1'b0;
        priority if (i_cmd.init_en) begin
            use_wr_en = 1'b1;
        end else if (i_cmd.exec && alloc_ok) begin
            use_wr_en   = 1'b1;
            use_wr_addr = r_head;
            use_wr_data = 1'b1;
        end else if (i_cmd.exec && rel_ok) begin
            use_wr_en   = 1'b1;
            use_wr_addr = r_rel_idx;
        end else begin
            use_wr_en = 1'b0;
        end
    end

    // Memories: one write and one registered read each.
    // A released entry becomes the tail, whose link is never read before the
    // next release overwrites it, so only the old tail's link is written.
    always_ff @(posedge i_clk) begin
        if (use_wr_en) begin
            r_in_use[use_wr_addr] <= use_wr_data;
        end
        if (i_cmd.init_en) begin
            r_link[r_init_cnt] <= init_link;
        end else if (i_cmd.link_wr) begin
            r_link[r_link_addr] <= r_rel_idx;
        end
        if (i_cmd.accept) begin
            r_use_rd  <= rd_in_range ? r_in_use[rd_rel_idx] : 1'b0;
            r_link_rd <= r_link[r_head];
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op           <= i_in_item.opcode;
            r_rel_idx      <= rd_rel_idx;
            r_rel_in_range <= rd_in_range;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
        end else if (i_cmd.init_en) begin
            r_init_cnt <= r_init_cnt + IW'(1);
        end
    end

    // Head, tail and empty flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= LAST_IDX;
            r_empty <= 1'b0;
        end else if (i_cmd.exec) begin
            if (alloc_ok) begin
                if (r_head == r_tail) begin
                    r_empty <= 1'b1;
                end else begin
                    r_head <= r_link_rd;
                end
            end else if (rel_ok) begin
                r_tail <= r_rel_idx;
                if (r_empty) begin
                    r_head  <= r_rel_idx;
                    r_empty <= 1'b0;
                end
            end
        end
    end

    // Old tail address kept for the link write that follows.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_link_addr <= r_tail;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_item.granted_index <= alloc_ok ? IDX_FIELD_W'(r_head) : '0;
            r_out_item.success       <= alloc_ok || rel_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Status back to the controller.
    assign o_status.init_last = (r_init_cnt == LAST_IDX);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.need_link = rel_ok && !r_empty;

endmodule

[rtl/core/fifo_free_list_allocator.sv]
// FIFO free-list allocator: pops entries from the head, appends releases at the tail.
// The item is captured on acceptance; the result register is loaded once the output is free.
// A new item is taken only after the current one is done; a release onto a non-empty list adds a link write.
// After reset a clearing pass over all NUM_ENTRIES entries builds the list; no item is taken then.
// Reset is synchronous and active low. Depends on ffla_pkg, ffla_ctrl and ffla_dp.
module fifo_free_list_allocator
    import ffla_pkg::*;
#(
    parameter int NUM_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_ffla_cmd    w_cmd;
    t_ffla_status w_status;

    // Sequencer.
    ffla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Pool storage and pointers.
    ffla_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // At most one datapath step is commanded in a cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.init_en, w_cmd.accept, w_cmd.exec, w_cmd.link_wr}))
        else $error("more than one datapath command at once");

    // An accepted item blocks the input until its work is done.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while an item is in work");

    // A new result only follows an executed item.
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.exec))
        else $error("result appeared without an executed item");

    // The tail link write always follows an accepted release step.
    a_link_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.link_wr |-> $past(w_cmd.exec))
        else $error("tail link written without a preceding release");

endmodule

[bench/tb.sv]
// Self-checking testbench for the FIFO free-list allocator (fifo_free_list_allocator).
// A directed table and then random request bursts are checked against a free-list mirror.
// Depends on ffla_pkg and the allocator RTL.
module tb;
    import ffla_pkg::*;

    localparam int NUM_ENTRIES  = 64;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 720;
    localparam int LONG_STALL   = 80;

    // One row of the directed script; typed rows carry their own expected result.
    typedef struct packed {
        logic                   opcode;
        logic [IDX_FIELD_W-1:0] index;
        logic [7:0]             reps;
        logic                   typed;
        logic [IDX_FIELD_W-1:0] want_index;
        logic                   want_success;
    } t_script_row;

    logic      i_clk;
    logic      r_rst_n;
    logic      r_in_valid;
    logic      o_in_ready;
    t_in_item  r_in_item;
    logic      o_out_valid;
    logic      r_out_ready;
    t_out_item o_out_item;

    // Mirror of the free list: links, head, tail, empty flag and in-use bits.
    logic [IDX_FIELD_W-1:0] fl_link [NUM_ENTRIES];
    logic [IDX_FIELD_W-1:0] fl_head;
    logic [IDX_FIELD_W-1:0] fl_tail;
    logic                   fl_empty;
    logic                   fl_taken [NUM_ENTRIES];

    t_out_item   due_results [$];
    t_script_row script [20];
    int          n_errors;
    int          n_results;
    int          n_cycles;
    bit          calm;

    fifo_free_list_allocator #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (r_rst_n),
        .i_in_valid (r_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (r_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(r_out_ready),
        .o_out_item (o_out_item)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one accepted request to the mirror and returns the result it must produce.
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item              res;
        logic [IDX_FIELD_W-1:0] idx;
        res = '0;
        idx = req.release_index;
        if (req.opcode == OP_ALLOC) begin
            if (!fl_empty) begin
                res.granted_index = fl_head;
                res.success = 1'b1;
                fl_taken[fl_head] = 1'b1;
                if (fl_head == fl_tail) begin
                    fl_empty = 1'b1;
                end else begin
                    fl_head = fl_link[fl_head];
                end
            end
        end else if (int'(idx) < NUM_ENTRIES && fl_taken[idx]) begin
            res.success = 1'b1;
            fl_taken[idx] = 1'b0;
            fl_link[idx] = '0;
            if (fl_empty) begin
                fl_head = idx;
                fl_tail = idx;
                fl_empty = 1'b0;
            end else begin
                fl_link[fl_tail] = idx;
                fl_tail = idx;
            end
        end
        return res;
    endfunction

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Release target: usually an entry that is handed out, otherwise any index.
    function automatic logic [IDX_FIELD_W-1:0] pick_release();
        logic [IDX_FIELD_W-1:0] held [$];
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (fl_taken[k]) held.push_back(IDX_FIELD_W'(k));
        end
        if (held.size() > 0 && $urandom_range(0, 9) < 8) begin
            return held[$urandom_range(0, held.size() - 1)];
        end
        return IDX_FIELD_W'($urandom_range(0, NUM_ENTRIES - 1));
    endfunction

    // Offers one item, waits for its acceptance and queues the result it is owed.
    // Called and returning at a falling edge.
    task automatic offer(input t_in_item req, input bit typed, input t_out_item typed_res);
        int        gap;
        t_out_item res;
        gap = calm ? 0 : idle_length();
        if (gap > 0) begin
            r_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        r_in_valid <= 1'b1;
        r_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        res = apply_request(req);
        due_results.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Receiver: random ready pattern, calm runs, and one long hold-off to back up the block.
    initial begin
        bit stall_done;
        int gap;
        stall_done = 1'b0;
        r_out_ready = 1'b0;
        wait (r_rst_n);
        @(negedge i_clk);
        forever begin
            if (!stall_done && n_results >= 200) begin
                r_out_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
                stall_done = 1'b1;
            end else begin
                gap = idle_length();
                if (gap > 0) begin
                    r_out_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                r_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(20, 60)) @(negedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (r_rst_n && o_out_valid && r_out_ready) begin
            n_results <= n_results + 1;
            if (due_results.size() == 0) begin
                $error("unexpected result: granted_index %0d, success %0d",
                       o_out_item.granted_index, o_out_item.success);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                if (o_out_item.granted_index !== want.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, o_out_item.granted_index);
                    n_errors++;
                end
                if (o_out_item.success !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, o_out_item.success);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random bursts, drain.
    initial begin
        t_in_item  req;
        t_out_item typed_res;
        int        sent;
        int        burst;
        int        mode;
        n_errors   = 0;
        n_results  = 0;
        n_cycles   = 0;
        calm       = 1'b0;
        r_rst_n    = 1'b0;
        r_in_valid = 1'b0;
        r_in_item  = '0;

        // After reset every entry is free and linked in index order.
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            fl_link[k]  = (k + 1 < NUM_ENTRIES) ? IDX_FIELD_W'(k + 1) : '0;
            fl_taken[k] = 1'b0;
        end
        fl_head  = '0;
        fl_tail  = IDX_FIELD_W'(NUM_ENTRIES - 1);
        fl_empty = 1'b0;

        // Directed rows: opcode, index, repeats, typed, expected index, expected success.
        script[0]  = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd0,  1'b1};
        // Releasing an entry that is still free is rejected.
        script[1]  = '{OP_RELEASE, 6'd63, 8'd1,  1'b1, 6'd0,  1'b0};
        script[2]  = '{OP_RELEASE, 6'd0,  8'd1,  1'b1, 6'd0,  1'b1};
        // Double release.
        script[3]  = '{OP_RELEASE, 6'd0,  8'd1,  1'b1, 6'd0,  1'b0};
        // The index field is ignored on allocate.
        script[4]  = '{OP_ALLOC,   6'd63, 8'd1,  1'b1, 6'd1,  1'b1};
        // Drain the pool down to its last free entry.
        script[5]  = '{OP_ALLOC,   6'd0,  8'd62, 1'b0, 6'd0,  1'b0};
        script[6]  = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd0,  1'b1};
        // Allocate from an empty pool.
        script[7]  = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd0,  1'b0};
        // Release into an empty pool makes the entry both head and tail.
        script[8]  = '{OP_RELEASE, 6'd63, 8'd1,  1'b1, 6'd0,  1'b1};
        script[9]  = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd63, 1'b1};
        script[10] = '{OP_ALLOC,   6'd42, 8'd1,  1'b1, 6'd0,  1'b0};
        script[11] = '{OP_RELEASE, 6'd5,  8'd1,  1'b1, 6'd0,  1'b1};
        script[12] = '{OP_RELEASE, 6'd42, 8'd1,  1'b1, 6'd0,  1'b1};
        script[13] = '{OP_RELEASE, 6'd21, 8'd1,  1'b1, 6'd0,  1'b1};
        script[14] = '{OP_RELEASE, 6'd42, 8'd1,  1'b1, 6'd0,  1'b0};
        // Freed entries come back in release order.
        script[15] = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd5,  1'b1};
        script[16] = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd42, 1'b1};
        script[17] = '{OP_ALLOC,   6'd0,  8'd1,  1'b1, 6'd21, 1'b1};
        script[18] = '{OP_ALLOC,   6'd0,  8'd1,  1'b0, 6'd0,  1'b0};
        script[19] = '{OP_RELEASE, 6'd0,  8'd1,  1'b0, 6'd0,  1'b0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        r_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table.
        foreach (script[r]) begin
            for (int n = 0; n < int'(script[r].reps); n++) begin
                req.opcode        = script[r].opcode;
                req.release_index = script[r].index;
                typed_res.granted_index = script[r].want_index;
                typed_res.success       = script[r].want_success;
                offer(req, script[r].typed, typed_res);
            end
        end

        // Random bursts: allocate-heavy ones empty the pool, release-heavy ones refill it, others mix.
        sent = 0;
        typed_res = '0;
        while (sent < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(10, 80);
            calm  = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
                case (mode)
                    0: req.opcode = ($urandom_range(0, 99) < 85) ? OP_ALLOC : OP_RELEASE;
                    1: req.opcode = ($urandom_range(0, 99) < 85) ? OP_RELEASE : OP_ALLOC;
                    default: req.opcode = $urandom_range(0, 1) ? OP_RELEASE : OP_ALLOC;
                endcase
                if (req.opcode == OP_RELEASE) begin
                    req.release_index = pick_release();
                end else begin
                    req.release_index = IDX_FIELD_W'($urandom_range(0, NUM_ENTRIES - 1));
                end
                offer(req, 1'b0, typed_res);
                sent++;
            end
        end
        r_in_valid <= 1'b0;

        // Drain the outstanding results, then watch a little longer for strays.
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
